@@ rtl/core/utt_pkg.sv @@
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types and constants for the utf-8 to utf-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utt_pkg;

	// default unit limit per message
	localparam int MAX_UNITS_DEF = 256;

	// input item kinds (carried on tuser)
	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// result kinds (carried on tuser)
	localparam logic RES_UNIT   = 1'b0;
	localparam logic RES_STATUS = 1'b1;

	// message status codes
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_REQUEST = 3'd1,
		ST_BAD_UTF8    = 3'd2,
		ST_NUL         = 3'd3,
		ST_TOO_LONG    = 3'd4
	} status_t;

	// utf-8 lead byte ranges
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;
	localparam logic [7:0] ASCII_END = 8'h80;

	// scalar limits
	localparam logic [20:0] MIN_CLS1    = 21'h000080;
	localparam logic [20:0] MIN_CLS2    = 21'h000800;
	localparam logic [20:0] MIN_CLS3    = 21'h010000;
	localparam logic [20:0] SCALAR_MAX  = 21'h10FFFF;
	localparam logic [20:0] SURR_LO     = 21'h00D800;
	localparam logic [20:0] SURR_HI     = 21'h00DFFF;
	localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
	localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
	localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

	// output queue
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_AW    = 2;
	localparam int OFIFO_CW    = 3;

	typedef struct packed {
		logic        kind;
		logic [15:0] code_unit;
		status_t     status;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/utt_decode.sv @@
// ----------------------------------------------------------------------------
// utt_decode
// Per-message utf-8 decode state and the combinational decode of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_decode import utt_pkg::*; #(
	parameter int MAX_UNITS = MAX_UNITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        kind,
	input  wire logic [7:0]  tbyte,
	input  wire logic [63:0] msg_id,
	input  wire logic [63:0] reserved_id,
	output logic [1:0]       res_cnt,
	output result_t          res0,
	output result_t          res1
);

	localparam int CW = $clog2(MAX_UNITS + 1);
	localparam logic [CW:0] UNIT_LIMIT = (CW + 1)'(MAX_UNITS);

	logic [1:0]    pend_q, pend_d;
	logic [20:0]   ps_q, ps_d;
	logic [1:0]    cls_q, cls_d;
	logic [CW-1:0] cnt_q, cnt_d;
	status_t       err_q, err_d;

	logic [20:0] ps_shift;
	logic        fin;
	logic [20:0] fin_s;
	logic [1:0]  fin_cls;
	logic [20:0] fin_min;
	logic        fin_two;
	logic [CW:0] cnt_sum;
	logic [19:0] fin_v;
	status_t     end_status;

	assign ps_shift = {ps_q[14:0], tbyte[5:0]};

	always_comb begin
		pend_d     = pend_q;
		ps_d       = ps_q;
		cls_d      = cls_q;
		cnt_d      = cnt_q;
		err_d      = err_q;
		fin        = 1'b0;
		fin_s      = '0;
		fin_cls    = '0;
		fin_min    = '0;
		fin_two    = 1'b0;
		cnt_sum    = '0;
		fin_v      = '0;
		end_status = ST_OK;
		res_cnt    = 2'd0;
		res0       = '{RES_UNIT, 16'h0000, ST_OK, 1'b0};
		res1       = '{RES_UNIT, 16'h0000, ST_OK, 1'b0};

		if (kind == KIND_END) begin
			// bad id wins over any text error
			priority if (msg_id == 64'd0 || msg_id == reserved_id) begin
				end_status = ST_BAD_REQUEST;
			end else if (err_q != ST_OK) begin
				end_status = err_q;
			end else if (pend_q != 2'd0) begin
				end_status = ST_BAD_UTF8;
			end else begin
				end_status = ST_OK;
			end
			res0    = '{RES_STATUS, 16'h0000, end_status, 1'b1};
			res_cnt = 2'd1;
			pend_d  = '0;
			ps_d    = '0;
			cls_d   = '0;
			cnt_d   = '0;
			err_d   = ST_OK;
		end else if (err_q == ST_OK) begin
			if (pend_q != 2'd0) begin
				if (tbyte[7:6] != 2'b10) begin
					err_d = ST_BAD_UTF8;
				end else begin
					pend_d = pend_q - 2'd1;
					if (pend_q == 2'd1) begin
						fin     = 1'b1;
						fin_s   = ps_shift;
						fin_cls = cls_q;
						ps_d    = '0;
						cls_d   = '0;
					end else begin
						ps_d = ps_shift;
					end
				end
			end else begin
				priority if (tbyte < ASCII_END) begin
					fin     = 1'b1;
					fin_s   = {13'd0, tbyte};
					fin_cls = 2'd0;
				end else if (tbyte >= LEAD2_MIN && tbyte <= LEAD2_MAX) begin
					ps_d   = {16'd0, tbyte[4:0]};
					cls_d  = 2'd1;
					pend_d = 2'd1;
				end else if (tbyte >= LEAD3_MIN && tbyte <= LEAD3_MAX) begin
					ps_d   = {17'd0, tbyte[3:0]};
					cls_d  = 2'd2;
					pend_d = 2'd2;
				end else if (tbyte >= LEAD4_MIN && tbyte <= LEAD4_MAX) begin
					ps_d   = {18'd0, tbyte[2:0]};
					cls_d  = 2'd3;
					pend_d = 2'd3;
				end else begin
					err_d = ST_BAD_UTF8;
				end
			end

			// complete scalar: range, nul and length checks, then emit one unit or a pair
			if (fin) begin
				unique case (fin_cls)
					2'd0:    fin_min = '0;
					2'd1:    fin_min = MIN_CLS1;
					2'd2:    fin_min = MIN_CLS2;
					default: fin_min = MIN_CLS3;
				endcase
				fin_two = fin_s > BMP_MAX;
				cnt_sum = {1'b0, cnt_q} + (fin_two ? (CW + 1)'(2) : (CW + 1)'(1));
				fin_v   = 20'(fin_s - MIN_CLS3);
				priority if (fin_s < fin_min || fin_s > SCALAR_MAX ||
						(fin_s >= SURR_LO && fin_s <= SURR_HI)) begin
					err_d = ST_BAD_UTF8;
				end else if (fin_s == 21'd0) begin
					err_d = ST_NUL;
				end else if (cnt_sum > UNIT_LIMIT) begin
					err_d = ST_TOO_LONG;
				end else if (fin_two) begin
					cnt_d   = cnt_sum[CW-1:0];
					res0    = '{RES_UNIT, {HI_SURR_TAG, fin_v[19:10]}, ST_OK, 1'b0};
					res1    = '{RES_UNIT, {LO_SURR_TAG, fin_v[9:0]}, ST_OK, 1'b0};
					res_cnt = 2'd2;
				end else begin
					cnt_d   = cnt_sum[CW-1:0];
					res0    = '{RES_UNIT, fin_s[15:0], ST_OK, 1'b0};
					res_cnt = 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			ps_q   <= '0;
			cls_q  <= '0;
			cnt_q  <= '0;
			err_q  <= ST_OK;
		end else if (step) begin
			pend_q <= pend_d;
			ps_q   <= ps_d;
			cls_q  <= cls_d;
			cnt_q  <= cnt_d;
			err_q  <= err_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/utt_ofifo.sv @@
// ----------------------------------------------------------------------------
// utt_ofifo
// Small result queue: up to two pushes per cycle, one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_ofifo import utt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] push_cnt,
	input  wire result_t    wdata0,
	input  wire result_t    wdata1,
	input  wire logic       pop,
	output logic            room2,
	output logic            rvalid,
	output result_t         rdata
);

	result_t               mem_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0]   wr_ptr_q;
	logic [OFIFO_AW-1:0]   rd_ptr_q;
	logic [OFIFO_CW-1:0]   cnt_q;
	logic [OFIFO_AW-1:0]   wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + OFIFO_AW'(1);
	assign room2     = cnt_q <= OFIFO_CW'(OFIFO_DEPTH - 2);
	assign rvalid    = cnt_q != '0;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= wdata0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_nx] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OFIFO_AW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OFIFO_AW'(1);
			end
			cnt_q <= cnt_q + OFIFO_CW'(push_cnt) - OFIFO_CW'(pop);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/utf8_to_utf16_validating_transcoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_validating_transcoder
// Strict utf-8 to utf-16 transcoder with per-message status and id check.
// ----------------------------------------------------------------------------
// usage
//   input stream: one transfer per utf-8 byte (tuser = 0, byte in tdata[7:0]),
//   closed by an end transfer (tuser = 1, request id in tdata[71:8]).
//   output stream: one transfer per utf-16 code unit (tuser = 0), then one
//   status transfer per message (tuser = 1, tlast = 1, status in tdata[18:16]).
//   a scalar above 0xFFFF gives two unit transfers (surrogate pair).
//   units of a message whose status is not ok are void for the receiver.
// throughput
//   one input transfer per cycle while the result queue has room; results
//   pass the input register, then decode into the result queue. the output
//   side moves one result per cycle while m_axis_tready is high.
// stalls
//   a four-entry result queue parts the two sides; the held item advances
//   while it holds two or fewer results, so a stalled receiver backs up into tready.
// reset
//   arst_n clears the decode state, queue and the input register; the
//   reserved id register resets to all ones; cfg_we loads it from cfg_wdata.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_validating_transcoder import utt_pkg::*; #(
	parameter int MAX_UNITS = MAX_UNITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: reserved request id
	input  wire logic        cfg_we,
	input  wire logic [63:0] cfg_wdata,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // [7:0] text_byte, [71:8] req_id
	input  wire logic        s_axis_tuser,  // [0] kind
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [15:0] code_unit, [18:16] status, zero above
	output logic             m_axis_tuser,  // [0] result_kind
	output logic             m_axis_tlast   // last
);

	// reserved id register
	logic [63:0] reserved_id_q;

	// input register
	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  tbyte_s1;
	logic [63:0] id_s1;

	// decode to queue
	logic       advance;
	logic       room2;
	logic [1:0] res_cnt;
	logic [1:0] push_cnt;
	result_t    res0;
	result_t    res1;
	result_t    out_res;
	logic       out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_id_q <= '1;
		end else if (cfg_we) begin
			reserved_id_q <= cfg_wdata;
		end
	end

	// the held item is decoded once the queue can take a surrogate pair
	assign advance       = valid_s1 && room2;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1  <= s_axis_tuser;
			tbyte_s1 <= s_axis_tdata[7:0];
			id_s1    <= s_axis_tdata[71:8];
		end
	end

	utt_decode #(
		.MAX_UNITS (MAX_UNITS)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.kind        (kind_s1),
		.tbyte       (tbyte_s1),
		.msg_id      (id_s1),
		.reserved_id (reserved_id_q),
		.res_cnt     (res_cnt),
		.res0        (res0),
		.res1        (res1)
	);

	assign push_cnt = advance ? res_cnt : 2'd0;

	utt_ofifo u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.wdata0   (res0),
		.wdata1   (res1),
		.pop      (out_valid && m_axis_tready),
		.room2    (room2),
		.rvalid   (out_valid),
		.rdata    (out_res)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = {5'd0, out_res.status, out_res.code_unit};
	assign m_axis_tuser  = out_res.kind;
	assign m_axis_tlast  = out_res.last;

endmodule

`default_nettype wire
